// File: hdl/i2cax_pkg.sv
package i2cax_pkg;

  // Phase codes of the sequencer
  localparam logic [3:0] PH_INIT_ADDR  = 4'd0;
  localparam logic [3:0] PH_INIT_REG   = 4'd1;
  localparam logic [3:0] PH_INIT_VAL   = 4'd2;
  localparam logic [3:0] PH_INIT_STOP  = 4'd3;
  localparam logic [3:0] PH_RD_ADDR_W  = 4'd4;
  localparam logic [3:0] PH_RD_REG     = 4'd5;
  localparam logic [3:0] PH_RD_RESTART = 4'd6;
  localparam logic [3:0] PH_RD_ADDR_R  = 4'd7;
  localparam logic [3:0] PH_RD_NACK    = 4'd8;
  localparam logic [3:0] PH_RD_DATA    = 4'd9;

  // Error codes
  localparam logic [2:0] ERR_OK           = 3'd0;
  localparam logic [2:0] ERR_RD_NO_START  = 3'd1;
  localparam logic [2:0] ERR_RD_NO_ADDR   = 3'd2;
  localparam logic [2:0] ERR_RD_NO_BTF    = 3'd3;
  localparam logic [2:0] ERR_INI_NO_START = 3'd4;
  localparam logic [2:0] ERR_INI_NO_ADDR  = 3'd5;
  localparam logic [2:0] ERR_INI_NO_TXE   = 3'd6;
  localparam logic [2:0] ERR_INI_NO_BTF   = 3'd7;

  // Buffer interrupt control codes
  localparam logic [1:0] IRQ_KEEP    = 2'd0;
  localparam logic [1:0] IRQ_ENABLE  = 2'd1;
  localparam logic [1:0] IRQ_DISABLE = 2'd2;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_DEVICE_ADDR = 3'd0;
  localparam logic [2:0] REG_CTRL_ADDR   = 3'd1;
  localparam logic [2:0] REG_CTRL_VALUE  = 3'd2;
  localparam logic [2:0] REG_X_ADDR      = 3'd3;
  localparam logic [2:0] REG_Y_ADDR      = 3'd4;
  localparam logic [2:0] REG_Z_ADDR      = 3'd5;

  // Configuration reset values
  localparam logic [6:0] RST_DEVICE_ADDR = 7'h1C;
  localparam logic [7:0] RST_CTRL_ADDR   = 8'h20;
  localparam logic [7:0] RST_CTRL_VALUE  = 8'b0100_0111;
  localparam logic [7:0] RST_X_ADDR      = 8'h29;
  localparam logic [7:0] RST_Y_ADDR      = 8'h2B;
  localparam logic [7:0] RST_Z_ADDR      = 8'h2D;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] control_register_address;
    logic [7:0] control_value;
    logic [7:0] x_register_address;
    logic [7:0] y_register_address;
    logic [7:0] z_register_address;
  } cfg_t;

  typedef struct packed {
    logic       flag_start_sent;
    logic       flag_address_done;
    logic       flag_tx_empty;
    logic       flag_byte_finished;
    logic       flag_rx_full;
    logic [7:0] rx_data;
  } in_item_t;

  typedef struct packed {
    logic              send_valid;
    logic [7:0]        send_byte;
    logic              issue_start;
    logic              issue_stop;
    logic              clear_ack;
    logic [1:0]        buffer_irq_ctrl;
    logic              clear_address_flag;
    logic              sample_valid;
    logic signed [7:0] sample_value;
    logic [1:0]        sample_axis;
    logic [2:0]        error_code;
  } out_item_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [1:0] axis_index;
  } seq_state_t;

endpackage

// File: hdl/i2cax_cfg_if.sv
interface i2cax_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [7:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

// File: hdl/i2cax_in_if.sv
interface i2cax_in_if;
  logic       valid;
  logic       ready;
  logic       flag_start_sent;
  logic       flag_address_done;
  logic       flag_tx_empty;
  logic       flag_byte_finished;
  logic       flag_rx_full;
  logic [7:0] rx_data;

  modport source (
    output valid, output flag_start_sent, output flag_address_done,
    output flag_tx_empty, output flag_byte_finished, output flag_rx_full,
    output rx_data, input ready
  );
  modport sink (
    input valid, input flag_start_sent, input flag_address_done,
    input flag_tx_empty, input flag_byte_finished, input flag_rx_full,
    input rx_data, output ready
  );
endinterface

// File: hdl/i2cax_out_if.sv
interface i2cax_out_if;
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [7:0]        send_byte;
  logic              issue_start;
  logic              issue_stop;
  logic              clear_ack;
  logic [1:0]        buffer_irq_ctrl;
  logic              clear_address_flag;
  logic              sample_valid;
  logic signed [7:0] sample_value;
  logic [1:0]        sample_axis;
  logic [2:0]        error_code;

  modport source (
    output valid, output send_valid, output send_byte, output issue_start,
    output issue_stop, output clear_ack, output buffer_irq_ctrl,
    output clear_address_flag, output sample_valid, output sample_value,
    output sample_axis, output error_code, input ready
  );
  modport sink (
    input valid, input send_valid, input send_byte, input issue_start,
    input issue_stop, input clear_ack, input buffer_irq_ctrl,
    input clear_address_flag, input sample_valid, input sample_value,
    input sample_axis, input error_code, output ready
  );
endinterface

// File: hdl/i2cax_cfg_regs.sv
module i2cax_cfg_regs
  import i2cax_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_DEVICE_ADDR: cfg_nxt.device_address           = wr_data[6:0];
        REG_CTRL_ADDR:   cfg_nxt.control_register_address = wr_data;
        REG_CTRL_VALUE:  cfg_nxt.control_value            = wr_data;
        REG_X_ADDR:      cfg_nxt.x_register_address       = wr_data;
        REG_Y_ADDR:      cfg_nxt.y_register_address       = wr_data;
        REG_Z_ADDR:      cfg_nxt.z_register_address       = wr_data;
        default:         cfg_nxt = cfg_r;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address           <= RST_DEVICE_ADDR;
      cfg_r.control_register_address <= RST_CTRL_ADDR;
      cfg_r.control_value            <= RST_CTRL_VALUE;
      cfg_r.x_register_address       <= RST_X_ADDR;
      cfg_r.y_register_address       <= RST_Y_ADDR;
      cfg_r.z_register_address       <= RST_Z_ADDR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/i2cax_step.sv
module i2cax_step
  import i2cax_pkg::*;
(
  input  cfg_t       cfg,
  input  seq_state_t state,
  input  in_item_t   item,
  output seq_state_t state_nxt,
  output out_item_t  result
);

  logic [7:0] wr_addr;
  logic [7:0] axis_reg;
  logic [1:0] axis_sat;

  assign wr_addr  = {cfg.device_address, 1'b0};
  assign axis_sat = (state.axis_index >= AXIS_Z) ? AXIS_Z : state.axis_index;

  always_comb begin
    unique case (state.axis_index)
      AXIS_X:  axis_reg = cfg.x_register_address;
      AXIS_Y:  axis_reg = cfg.y_register_address;
      default: axis_reg = cfg.z_register_address;
    endcase
  end

  always_comb begin
    result    = '0;
    state_nxt = state;
    unique case (state.phase)
      PH_INIT_ADDR: begin
        if (!item.flag_start_sent) begin
          result.error_code = ERR_INI_NO_START;
        end else begin
          result.send_valid = 1'b1;
          result.send_byte  = wr_addr;
          state_nxt.phase   = PH_INIT_REG;
        end
      end
      PH_INIT_REG: begin
        if (!item.flag_address_done) begin
          result.error_code = ERR_INI_NO_ADDR;
        end else begin
          result.clear_address_flag = 1'b1;
          result.send_valid         = 1'b1;
          result.send_byte          = cfg.control_register_address;
          state_nxt.phase           = PH_INIT_VAL;
        end
      end
      PH_INIT_VAL: begin
        if (!item.flag_tx_empty) begin
          result.error_code = ERR_INI_NO_TXE;
        end else begin
          result.send_valid = 1'b1;
          result.send_byte  = cfg.control_value;
          state_nxt.phase   = PH_INIT_STOP;
        end
      end
      PH_INIT_STOP: begin
        if (!item.flag_byte_finished) begin
          result.error_code = ERR_INI_NO_BTF;
        end else begin
          result.issue_stop      = 1'b1;
          result.buffer_irq_ctrl = IRQ_DISABLE;
          result.issue_start     = 1'b1;
          state_nxt.phase        = PH_RD_ADDR_W;
        end
      end
      PH_RD_ADDR_W: begin
        if (!item.flag_start_sent) begin
          result.error_code = ERR_RD_NO_START;
        end else begin
          result.buffer_irq_ctrl = IRQ_ENABLE;
          result.send_valid      = 1'b1;
          result.send_byte       = wr_addr;
          state_nxt.phase        = PH_RD_REG;
        end
      end
      PH_RD_REG: begin
        if (!item.flag_address_done) begin
          result.error_code = ERR_RD_NO_ADDR;
        end else begin
          result.clear_address_flag = 1'b1;
          result.send_valid         = 1'b1;
          result.send_byte          = axis_reg;
          state_nxt.phase           = PH_RD_RESTART;
        end
      end
      PH_RD_RESTART: begin
        if (!item.flag_byte_finished) begin
          result.error_code = ERR_RD_NO_BTF;
        end else begin
          result.issue_start     = 1'b1;
          result.buffer_irq_ctrl = IRQ_DISABLE;
          state_nxt.phase        = PH_RD_ADDR_R;
        end
      end
      PH_RD_ADDR_R: begin
        if (!item.flag_start_sent) begin
          result.error_code = ERR_RD_NO_START;
        end else begin
          result.buffer_irq_ctrl = IRQ_ENABLE;
          result.send_valid      = 1'b1;
          result.send_byte       = wr_addr | 8'd1;
          result.clear_ack       = 1'b1;
          state_nxt.phase        = PH_RD_NACK;
        end
      end
      PH_RD_NACK: begin
        if (!item.flag_address_done) begin
          result.error_code = ERR_RD_NO_ADDR;
        end else begin
          result.clear_address_flag = 1'b1;
          result.issue_stop         = 1'b1;
          state_nxt.phase           = PH_RD_DATA;
        end
      end
      PH_RD_DATA: begin
        // hold quietly until the byte lands
        if (item.flag_rx_full) begin
          result.sample_valid  = 1'b1;
          result.sample_value  = item.rx_data;
          result.sample_axis   = axis_sat;
          result.issue_start   = 1'b1;
          state_nxt.axis_index = (state.axis_index >= AXIS_Z) ? AXIS_X
                                 : state.axis_index + 2'd1;
          state_nxt.phase      = PH_RD_ADDR_W;
        end
      end
      default: begin
        state_nxt.phase = PH_INIT_ADDR;
      end
    endcase
  end

endmodule

// File: hdl/i2c_accel_init_and_axis_poll_sequencer.sv
// I2C master sequencer for an accelerometer. Each input transaction is one
// bus event from the I2C master (status flags plus the receive data byte);
// each event yields exactly one result transaction telling the master what
// to do next. After reset the block writes control_value to the control
// register once, then reads the X, Y and Z axis registers in turn forever,
// each with a repeated start and a NACKed single byte, and reports the byte
// as a signed sample with its axis. A missing expected flag reports an error
// code and leaves the sequence where it is; the data phase instead waits
// for rx full with no error. Rate: one event per clock while the output is
// ready; an event goes from the input register via one phase decode into
// the result register, updating the phase and axis registers. Configuration
// writes are always ready; write them only while no event is in flight.
module i2c_accel_init_and_axis_poll_sequencer
  import i2cax_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  i2cax_cfg_if.sink          cfg_bus,
  i2cax_in_if.sink           in_bus,
  i2cax_out_if.source        out_bus
);

  cfg_t       cfg;
  seq_state_t state_r;
  seq_state_t state_nxt;
  seq_state_t step_state_nxt;
  out_item_t  step_result;

  logic       in_valid_r;
  logic       in_valid_nxt;
  in_item_t   in_item_r;
  in_item_t   in_item;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_item_r;

  logic       in_take;
  logic       advance;

  // Register file, always ready
  assign cfg_bus.ready = 1'b1;

  i2cax_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.reg_index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  // Move the held event into the result register when that slot is free
  // or drains this cycle; take a new event whenever the input slot frees.
  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  assign in_item.flag_start_sent    = in_bus.flag_start_sent;
  assign in_item.flag_address_done  = in_bus.flag_address_done;
  assign in_item.flag_tx_empty      = in_bus.flag_tx_empty;
  assign in_item.flag_byte_finished = in_bus.flag_byte_finished;
  assign in_item.flag_rx_full       = in_bus.flag_rx_full;
  assign in_item.rx_data            = in_bus.rx_data;

  i2cax_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .item      (in_item_r),
    .state_nxt (step_state_nxt),
    .result    (step_result)
  );

  always_comb begin
    in_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);
    state_nxt     = advance ? step_state_nxt : state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      state_r.phase      <= PH_INIT_ADDR;
      state_r.axis_index <= AXIS_X;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= step_result;
    end
  end

  assign out_bus.valid              = out_valid_r;
  assign out_bus.send_valid         = out_item_r.send_valid;
  assign out_bus.send_byte          = out_item_r.send_byte;
  assign out_bus.issue_start        = out_item_r.issue_start;
  assign out_bus.issue_stop         = out_item_r.issue_stop;
  assign out_bus.clear_ack          = out_item_r.clear_ack;
  assign out_bus.buffer_irq_ctrl    = out_item_r.buffer_irq_ctrl;
  assign out_bus.clear_address_flag = out_item_r.clear_address_flag;
  assign out_bus.sample_valid       = out_item_r.sample_valid;
  assign out_bus.sample_value       = out_item_r.sample_value;
  assign out_bus.sample_axis        = out_item_r.sample_axis;
  assign out_bus.error_code         = out_item_r.error_code;

endmodule
